// ----- src/sddc_pkg.sv -----
// Shared definitions for the switch debouncer with double-change detection:
// register indexes, reset values, default counter width and the flag layout.
// No dependencies.
`timescale 1ns / 1ps

package sddc_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned CFG_DATA_BITS  = 16;
    localparam int unsigned CFG_INDEX_BITS = 2;

    localparam logic [CFG_DATA_BITS-1:0] DEBOUNCE_TICKS_RESET = 16'd20;
    localparam logic [CFG_DATA_BITS-1:0] DOUBLE_TICKS_RESET   = 16'd500;
    localparam logic                     START_LEVEL_RESET    = 1'b0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE_TICKS = 2'd0,
        CFG_DOUBLE_TICKS   = 2'd1,
        CFG_START_LEVEL    = 2'd2
    } cfg_index_t;

    // Bit 0 is the changed flag, bit 4 the double fell flag.
    typedef struct packed {
        logic double_fell;
        logic double_rose;
        logic fell;
        logic rose;
        logic changed;
    } flags_t;

endpackage

// ----- src/switch_debounce_double_change.sv -----
// Switch debouncer with double-change detection; uses sddc_pkg.
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the result side is not stalled.
// The rate is set by the single state update between the two registers.
// Reset clears the debounce state, counters, flags register and valid bits and loads the register defaults.
`timescale 1ns / 1ps

module switch_debounce_double_change #(
    parameter int unsigned COUNT_BITS = sddc_pkg::COUNT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sddc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sddc_pkg::CFG_DATA_BITS-1:0]   cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 pin_level,
    input  logic [4:0]                           clear_mask,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 level,
    output logic                                 changed,
    output logic                                 rose,
    output logic                                 fell,
    output logic                                 double_rose,
    output logic                                 double_fell,
    output logic                                 debouncing
);

    import sddc_pkg::*;

    localparam int unsigned CMP_BITS =
        (COUNT_BITS > CFG_DATA_BITS) ? COUNT_BITS : CFG_DATA_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [CFG_DATA_BITS-1:0] debounce_ticks_reg;
    logic [CFG_DATA_BITS-1:0] double_ticks_reg;

    logic                     active_reg, active_next;
    logic                     latched_reg, latched_next;
    logic [COUNT_BITS-1:0]    settle_reg, settle_next;
    logic [COUNT_BITS-1:0]    rise_cnt_reg, rise_cnt_next;
    logic [COUNT_BITS-1:0]    fall_cnt_reg, fall_cnt_next;
    flags_t                   flags_reg, flags_next, flags_report;

    logic                     s1_valid_reg;
    logic                     s1_pin_reg;
    flags_t                   s1_mask_reg;

    logic                     out_valid_reg;
    logic                     level_reg;
    flags_t                   out_flags_reg;
    logic                     debouncing_reg;

    logic                     out_load;
    logic                     s1_adv;
    logic                     cfg_write;
    logic                     edge_seen;
    logic [COUNT_BITS-1:0]    settle_inc, rise_inc, fall_inc;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_load = !out_valid_reg || out_ready;
    assign s1_adv   = s1_valid_reg && out_load;
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        settle_inc = (settle_reg == CNT_MAX) ? settle_reg : settle_reg + CNT_ONE;
        rise_inc   = (rise_cnt_reg == CNT_MAX) ? rise_cnt_reg : rise_cnt_reg + CNT_ONE;
        fall_inc   = (fall_cnt_reg == CNT_MAX) ? fall_cnt_reg : fall_cnt_reg + CNT_ONE;

        active_next   = active_reg;
        latched_next  = latched_reg;
        settle_next   = settle_inc;
        rise_cnt_next = rise_inc;
        fall_cnt_next = fall_inc;
        flags_report  = flags_reg;
        edge_seen     = !active_reg && (s1_pin_reg != latched_reg);

        if (!active_reg)
        begin
            if (edge_seen)
            begin
                latched_next         = s1_pin_reg;
                flags_report.changed = 1'b1;
                if (s1_pin_reg)
                begin
                    flags_report.rose = 1'b1;
                    if (CMP_BITS'(rise_inc) < CMP_BITS'(double_ticks_reg))
                    begin
                        flags_report.double_rose = 1'b1;
                    end
                    rise_cnt_next = '0;
                end
                else
                begin
                    flags_report.fell = 1'b1;
                    if (CMP_BITS'(fall_inc) < CMP_BITS'(double_ticks_reg))
                    begin
                        flags_report.double_fell = 1'b1;
                    end
                    fall_cnt_next = '0;
                end
                settle_next = '0;
                active_next = 1'b1;
            end
        end
        else
        begin
            if (s1_pin_reg != latched_reg)
            begin
                settle_next = '0;
            end
            if (CMP_BITS'(settle_next) >= CMP_BITS'(debounce_ticks_reg))
            begin
                active_next = 1'b0;
            end
        end

        flags_next = flags_report & ~s1_mask_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= DEBOUNCE_TICKS_RESET;
            double_ticks_reg   <= DOUBLE_TICKS_RESET;
            active_reg         <= 1'b0;
            latched_reg        <= START_LEVEL_RESET;
            settle_reg         <= '0;
            rise_cnt_reg       <= '0;
            fall_cnt_reg       <= '0;
            flags_reg          <= '0;
        end
        else
        begin
            if (s1_adv)
            begin
                active_reg   <= active_next;
                latched_reg  <= latched_next;
                settle_reg   <= settle_next;
                rise_cnt_reg <= rise_cnt_next;
                fall_cnt_reg <= fall_cnt_next;
                flags_reg    <= flags_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data;
                    CFG_DOUBLE_TICKS:   double_ticks_reg   <= cfg_data;
                    CFG_START_LEVEL:    latched_reg        <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_pin_reg  <= pin_level;
            s1_mask_reg <= flags_t'(clear_mask);
        end
        if (s1_adv)
        begin
            level_reg      <= latched_next;
            out_flags_reg  <= flags_report;
            debouncing_reg <= active_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign level       = level_reg;
    assign changed     = out_flags_reg.changed;
    assign rose        = out_flags_reg.rose;
    assign fell        = out_flags_reg.fell;
    assign double_rose = out_flags_reg.double_rose;
    assign double_fell = out_flags_reg.double_fell;
    assign debouncing  = debouncing_reg;

    // An item held in the input register is never dropped while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_load |=> s1_valid_reg)
        else $error("input stage item lost during stall");

    // An edge seen while stable is reported with the changed flag and starts debouncing.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && edge_seen |=> out_valid_reg && out_flags_reg.changed && debouncing_reg)
        else $error("edge not reported");

    // A rise restarts the rise counter.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && edge_seen && s1_pin_reg |=> rise_cnt_reg == '0)
        else $error("rise counter not restarted");

    // A bounce while debouncing restarts the settle count.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && active_reg && (s1_pin_reg != latched_reg) |=> settle_reg == '0)
        else $error("settle count not restarted on bounce");

endmodule
